/* hdl/bale_pkg.sv */
// Shared types and codes for the bounded array list engine.
// Used by bale_cell, bale_chain and bounded_array_list_engine; no dependencies.
package bale_pkg;

    typedef enum logic [3:0] {
        FN_PUSH_BACK  = 4'd0,
        FN_POP_BACK   = 4'd1,
        FN_PUSH_FRONT = 4'd2,
        FN_POP_FRONT  = 4'd3,
        FN_INSERT     = 4'd4,
        FN_ERASE      = 4'd5,
        FN_FIND       = 4'd6,
        FN_REMOVE     = 4'd7,
        FN_REMOVE_ALL = 4'd8,
        FN_SORT       = 4'd9,
        FN_BSEARCH    = 4'd10,
        FN_DUMP       = 4'd11,
        FN_CLEAR      = 4'd12
    } func_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_ERASE_ONE,
        S_PURGE,
        S_SORT,
        S_BS_SEEK,
        S_UNWIND,
        S_DUMP,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_WRITE,
        C_INSERT,
        C_ERASE,
        C_ROTATE,
        C_PURGE,
        C_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

endpackage

/* hdl/bale_cell.sv */
// One storage cell of the list chain: holds a single element and trades with neighbors.
// Depends on bale_pkg for the cell control struct.
module bale_cell #(
    parameter int DW  = 32,
    parameter int IW  = 4,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                   aclk,
    input  bale_pkg::cell_ctrl_t   ctrl,
    input  logic [IW-1:0]          pos,
    input  logic [CW-1:0]          count,
    input  logic [DW-1:0]          value,
    input  logic [DW-1:0]          left_data,
    input  logic [DW-1:0]          right_data,
    input  logic                   chain_in,
    output logic [DW-1:0]          data_out,
    output logic                   chain_out
);

    localparam logic PARITY = 1'(IDX % 2);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic          match;

    assign match     = (data_reg == value) && (CW'(IDX) < count);
    assign chain_out = chain_in | match;
    assign data_out  = data_reg;

    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            bale_pkg::C_HOLD: begin
            end
            bale_pkg::C_WRITE: begin
                if (IW'(IDX) == pos) data_next = value;
            end
            bale_pkg::C_INSERT: begin
                if (IW'(IDX) == pos) data_next = value;
                else if (IW'(IDX) > pos) data_next = left_data;
            end
            bale_pkg::C_ERASE: begin
                if (IW'(IDX) >= pos) data_next = right_data;
            end
            bale_pkg::C_ROTATE: begin
                data_next = right_data;
            end
            bale_pkg::C_PURGE: begin
                if (chain_out) data_next = right_data;
            end
            bale_pkg::C_SORT: begin
                if (PARITY == ctrl.phase) begin
                    if ((CW'(IDX + 1) < count) && ($signed(data_reg) > $signed(right_data)))
                        data_next = right_data;
                end else begin
                    if ((IDX > 0) && (CW'(IDX) < count)
                        && ($signed(left_data) > $signed(data_reg)))
                        data_next = left_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

/* hdl/bale_chain.sv */
// Ring of list cells; cell 0 is the head that the controller reads.
// Depends on bale_pkg and bale_cell.
module bale_chain #(
    parameter int DEPTH = 16,
    parameter int DW    = 32,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic                 aclk,
    input  bale_pkg::cell_ctrl_t ctrl,
    input  logic [IW-1:0]        pos,
    input  logic [CW-1:0]        count,
    input  logic [DW-1:0]        value,
    output logic [DW-1:0]        head,
    output logic                 any_match
);

    logic [DW-1:0] cell_data [DEPTH];
    logic          chain [DEPTH+1];

    assign chain[0]  = 1'b0;
    assign head      = cell_data[0];
    assign any_match = chain[DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bale_cell #(
            .DW (DW),
            .IW (IW),
            .CW (CW),
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .pos       (pos),
            .count     (count),
            .value     (value),
            .left_data (cell_data[(i + DEPTH - 1) % DEPTH]),
            .right_data(cell_data[(i + 1) % DEPTH]),
            .chain_in  (chain[i]),
            .data_out  (cell_data[i]),
            .chain_out (chain[i+1])
        );
    end

endmodule

/* hdl/bounded_array_list_engine.sv */
// Top level of the bounded array list engine: request/result handshakes and sequencer.
// Depends on bale_pkg and bale_chain (which holds the bale_cell row).
//
//  channel | ports             | direction | payload
//  --------+-------------------+-----------+---------------------------------------------
//  request | s_tvalid/tready/  | in        | func, position, operand_value
//          | s_tdata           |           |
//  result  | m_tvalid/tready/  | out       | status, found_index, found, element,
//          | m_tdata, m_tlast  |           | item_count; tlast marks final result
//
// Flow: one request is worked at a time. Push, pop, insert, erase and clear act in the
// execute state and then deliver; find and remove scan the whole ring, remove_all drops
// matches until none is left, and bsearch rotates to each midpoint and then unwinds. The
// cell ring rotates one place per cycle (in dump, held while a result waits), which
// sets find, dump and bsearch time; sort is DEPTH odd-even compare-swap passes.
// Reset clears the fill count and control; element cells hold no reset value.
// A request is taken in idle even while the previous result waits on m_tready.
module bounded_array_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[3:0], position[8:4], operand_value[40:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], found_index[6:3], found[7],
                                   // element[39:8], item_count[44:40]
    output logic        m_tlast
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = DATA_WIDTH;

    // control state
    bale_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    r_reg, r_next;        // element index now sitting in cell 0
    logic [IW-1:0]    k_reg, k_next;        // sort pass counter
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic             fnd_reg, fnd_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [2:0]       status_reg, status_next;
    logic             m_valid_reg, m_valid_next;

    // request and result payload
    bale_pkg::func_t  func_reg, func_next;
    logic [4:0]       pos_reg, pos_next;
    logic [DW-1:0]    v_reg, v_next;
    logic [44:0]      m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    // chain interface
    bale_pkg::cell_ctrl_t ctrl;
    logic [IW-1:0]        cell_pos;
    logic [DW-1:0]        head;
    logic                 any_match;

    // shared conditions
    logic          in_accept;
    logic          out_free;
    logic          full;
    logic          empty;
    logic [4:0]    pos_eff;
    logic          ins_bad;
    logic          ers_bad;
    logic          r_last;
    logic [IW-1:0] r_inc;
    logic          r_in;
    logic          head_eq;
    logic          head_lt;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          at_mid;
    logic          bs_done;
    logic          dump_last;
    logic          scan_hit;
    logic [63:0]   op_ext;
    logic [63:0]   head_ext;

    assign s_tready  = (state_reg == bale_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, m_data_reg};
    assign m_tlast   = m_last_reg;

    assign op_ext   = {{32{s_tdata[40]}}, s_tdata[40:9]};
    assign head_ext = 64'(head);

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_eff = ((func_reg == bale_pkg::FN_PUSH_FRONT)
                      || (func_reg == bale_pkg::FN_POP_FRONT)) ? 5'd0 : pos_reg;
    assign ins_bad = {3'b000, pos_eff} >  8'(count_reg);
    assign ers_bad = {3'b000, pos_eff} >= 8'(count_reg);

    assign r_last  = (r_reg == IW'(DEPTH - 1));
    assign r_inc   = r_last ? '0 : r_reg + 1'b1;
    assign r_in    = (CW'(r_reg) < count_reg);
    assign head_eq = (head == v_reg);
    assign head_lt = ($signed(head) < $signed(v_reg));
    assign scan_hit = r_in && head_eq && !fnd_reg;

    // midpoint of the half-open window [lo, hi): floor((lo + hi - 1) / 2)
    assign mid_sum = (CW+1)'(lo_reg) + (CW+1)'(hi_reg) - 1'b1;
    assign mid     = mid_sum[CW:1];
    assign at_mid  = (CW'(r_reg) == mid);
    assign bs_done = head_lt ? ((CW+1)'(mid) + 1'b1 >= (CW+1)'(hi_reg)) : (lo_reg >= mid);
    assign dump_last = ((CW+1)'(r_reg) + 1'b1) == (CW+1)'(count_reg);

    bale_chain #(
        .DEPTH(DEPTH),
        .DW   (DW),
        .IW   (IW),
        .CW   (CW)
    ) u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .pos      (cell_pos),
        .count    (count_reg),
        .value    (v_reg),
        .head     (head),
        .any_match(any_match)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bale_pkg::S_IDLE: begin
                if (in_accept) state_next = bale_pkg::S_EXEC;
            end
            bale_pkg::S_EXEC: begin
                unique case (func_reg)
                    bale_pkg::FN_FIND,
                    bale_pkg::FN_REMOVE:     state_next = bale_pkg::S_SCAN;
                    bale_pkg::FN_REMOVE_ALL: state_next = bale_pkg::S_PURGE;
                    bale_pkg::FN_SORT:       state_next = bale_pkg::S_SORT;
                    bale_pkg::FN_BSEARCH:    state_next = empty ? bale_pkg::S_RESP
                                                                : bale_pkg::S_BS_SEEK;
                    bale_pkg::FN_DUMP:       state_next = empty ? bale_pkg::S_RESP
                                                                : bale_pkg::S_DUMP;
                    default:                 state_next = bale_pkg::S_RESP;
                endcase
            end
            bale_pkg::S_SCAN: begin
                if (r_last) begin
                    if ((func_reg == bale_pkg::FN_REMOVE) && (fnd_reg || scan_hit))
                        state_next = bale_pkg::S_ERASE_ONE;
                    else
                        state_next = bale_pkg::S_RESP;
                end
            end
            bale_pkg::S_ERASE_ONE: state_next = bale_pkg::S_RESP;
            bale_pkg::S_PURGE: begin
                if (!any_match) state_next = bale_pkg::S_RESP;
            end
            bale_pkg::S_SORT: begin
                if (k_reg == IW'(DEPTH - 1)) state_next = bale_pkg::S_RESP;
            end
            bale_pkg::S_BS_SEEK: begin
                if (at_mid && (head_eq || bs_done)) state_next = bale_pkg::S_UNWIND;
            end
            bale_pkg::S_UNWIND: begin
                if (r_reg == '0) state_next = bale_pkg::S_RESP;
            end
            bale_pkg::S_DUMP: begin
                if (r_last && (!r_in || out_free)) state_next = bale_pkg::S_IDLE;
            end
            bale_pkg::S_RESP: begin
                if (out_free) state_next = bale_pkg::S_IDLE;
            end
            default: state_next = bale_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next   = count_reg;
        r_next       = r_reg;
        k_next       = k_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        fnd_next     = fnd_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        func_next    = func_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        ctrl.op      = bale_pkg::C_HOLD;
        ctrl.phase   = k_reg[0];
        cell_pos     = IW'(pos_eff);

        unique case (state_reg)
            bale_pkg::S_IDLE: begin
                if (in_accept) begin
                    func_next = bale_pkg::func_t'(s_tdata[3:0]);
                    pos_next  = s_tdata[8:4];
                    v_next    = op_ext[DW-1:0];
                end
            end
            bale_pkg::S_EXEC: begin
                status_next = bale_pkg::ST_OK;
                fnd_next    = 1'b0;
                idx_next    = '0;
                r_next      = '0;
                unique case (func_reg)
                    bale_pkg::FN_PUSH_BACK: begin
                        if (full) status_next = bale_pkg::ST_FULL;
                        else begin
                            ctrl.op    = bale_pkg::C_WRITE;
                            cell_pos   = IW'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bale_pkg::FN_POP_BACK: begin
                        if (empty) status_next = bale_pkg::ST_EMPTY;
                        else count_next = count_reg - 1'b1;
                    end
                    bale_pkg::FN_PUSH_FRONT,
                    bale_pkg::FN_INSERT: begin
                        if (full) status_next = bale_pkg::ST_FULL;
                        else if (ins_bad) status_next = bale_pkg::ST_BADPOS;
                        else begin
                            ctrl.op    = bale_pkg::C_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bale_pkg::FN_POP_FRONT,
                    bale_pkg::FN_ERASE: begin
                        if (empty) status_next = bale_pkg::ST_EMPTY;
                        else if (ers_bad) status_next = bale_pkg::ST_BADPOS;
                        else begin
                            ctrl.op    = bale_pkg::C_ERASE;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    bale_pkg::FN_SORT: k_next = '0;
                    bale_pkg::FN_BSEARCH: begin
                        lo_next     = '0;
                        hi_next     = count_reg;
                        status_next = bale_pkg::ST_NOTFOUND;
                    end
                    bale_pkg::FN_DUMP: begin
                        if (empty) status_next = bale_pkg::ST_EMPTY;
                    end
                    bale_pkg::FN_CLEAR: count_next = '0;
                    default: begin
                    end
                endcase
            end
            bale_pkg::S_SCAN: begin
                // rotate the whole ring once, watching the head for the first match
                ctrl.op = bale_pkg::C_ROTATE;
                r_next  = r_inc;
                if (scan_hit) begin
                    fnd_next = 1'b1;
                    idx_next = r_reg;
                end
                if (r_last) begin
                    if (fnd_reg || scan_hit) status_next = bale_pkg::ST_OK;
                    else status_next = bale_pkg::ST_NOTFOUND;
                end
            end
            bale_pkg::S_ERASE_ONE: begin
                ctrl.op     = bale_pkg::C_ERASE;
                cell_pos    = idx_reg;
                count_next  = count_reg - 1'b1;
                idx_next    = '0;
                fnd_next    = 1'b0;
                status_next = bale_pkg::ST_OK;
            end
            bale_pkg::S_PURGE: begin
                // drop the first match per cycle until none is left
                ctrl.op = bale_pkg::C_PURGE;
                if (any_match) count_next = count_reg - 1'b1;
            end
            bale_pkg::S_SORT: begin
                ctrl.op = bale_pkg::C_SORT;
                k_next  = k_reg + 1'b1;
            end
            bale_pkg::S_BS_SEEK: begin
                if (at_mid) begin
                    if (head_eq) begin
                        fnd_next    = 1'b1;
                        idx_next    = r_reg;
                        status_next = bale_pkg::ST_OK;
                    end else if (head_lt) begin
                        lo_next = mid + 1'b1;
                    end else begin
                        hi_next = mid;
                    end
                end else begin
                    ctrl.op = bale_pkg::C_ROTATE;
                    r_next  = r_inc;
                end
            end
            bale_pkg::S_UNWIND: begin
                // advance the ring back to its home position
                if (r_reg != '0) begin
                    ctrl.op = bale_pkg::C_ROTATE;
                    r_next  = r_inc;
                end
            end
            bale_pkg::S_DUMP: begin
                if (!r_in || out_free) begin
                    ctrl.op = bale_pkg::C_ROTATE;
                    r_next  = r_inc;
                end
                if (r_in && out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'(count_reg), head_ext[31:0], 1'b0, 4'd0,
                                    bale_pkg::ST_OK};
                    m_last_next  = dump_last;
                end
            end
            bale_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'(count_reg), 32'd0, fnd_reg, 4'(idx_reg), status_reg};
                    m_last_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bale_pkg::S_IDLE;
            count_reg   <= '0;
            r_reg       <= '0;
            k_reg       <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            fnd_reg     <= 1'b0;
            idx_reg     <= '0;
            status_reg  <= bale_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            r_reg       <= r_next;
            k_reg       <= k_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            fnd_reg     <= fnd_next;
            idx_reg     <= idx_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bale_pkg::S_IDLE) |-> (r_reg == '0))
        else $error("cell ring not at home position when idle");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == bale_pkg::S_EXEC))
        else $error("accepted request not executed");
`endif

endmodule

/* tb/tb.sv */
// Self-checking bench for the bounded array list engine.
// Drives list requests over the stream input and scores every result against a built-in list model.
// Depends on bale_pkg and bounded_array_list_engine.
module tb;

    localparam int DEPTH = 16;
    localparam int TIMEOUT_CYCLES = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  found_index;
        logic        found;
        logic [31:0] element;
        logic [4:0]  item_count;
        logic        last;
    } result_t;

    typedef struct {
        logic [3:0]  fn;
        logic [4:0]  pos;
        logic [31:0] val;
        bit          typed;
        logic [2:0]  status;
        logic [4:0]  count;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    bounded_array_list_engine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // func[3:0], position[8:4], operand_value[40:9]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // status[2:0], found_index[6:3], found[7],
                               // element[39:8], item_count[44:40]
        .m_tlast  (m_tlast)
    );

    // list model state
    logic [31:0] list_words [DEPTH];
    int          list_len;
    result_t     pending_results [$];
    int          error_count = 0;
    int          table_errors;
    int          idle_cycles = 0;
    int          sent_count;
    int          recv_count = 0;
    bit          quiet_phase;
    bit          hold_sink;
    int          long_hold;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the list model and queue what it must answer.
    function automatic void apply_request(logic [3:0] fn, logic [4:0] pos_in,
                                          logic [31:0] val);
        logic [2:0]  status;
        logic [3:0]  idx;
        logic        fnd;
        int          pos;
        int          i;
        int          j;
        int          lo;
        int          hi;
        int          mid;
        logic [31:0] t;
        result_t     r;
        status = bale_pkg::ST_OK;
        idx = '0;
        fnd = 1'b0;
        pos = int'(pos_in);
        case (fn)
            bale_pkg::FN_PUSH_BACK: begin
                if (list_len >= DEPTH) status = bale_pkg::ST_FULL;
                else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            bale_pkg::FN_POP_BACK: begin
                if (list_len == 0) status = bale_pkg::ST_EMPTY;
                else list_len--;
            end
            bale_pkg::FN_PUSH_FRONT, bale_pkg::FN_INSERT: begin
                if (fn == bale_pkg::FN_PUSH_FRONT) pos = 0;
                if (list_len >= DEPTH) status = bale_pkg::ST_FULL;
                else if (pos > list_len) status = bale_pkg::ST_BADPOS;
                else begin
                    for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            bale_pkg::FN_POP_FRONT, bale_pkg::FN_ERASE: begin
                if (fn == bale_pkg::FN_POP_FRONT) pos = 0;
                if (list_len == 0) status = bale_pkg::ST_EMPTY;
                else if (pos >= list_len) status = bale_pkg::ST_BADPOS;
                else begin
                    for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            bale_pkg::FN_FIND, bale_pkg::FN_REMOVE: begin
                status = bale_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_words[i] == val) begin
                        status = bale_pkg::ST_OK;
                        break;
                    end
                end
                if (status == bale_pkg::ST_OK) begin
                    if (fn == bale_pkg::FN_FIND) begin
                        fnd = 1'b1;
                        idx = i[3:0];
                    end else begin
                        for (j = i; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
                        list_len--;
                    end
                end
            end
            bale_pkg::FN_REMOVE_ALL: begin
                i = 0;
                while (i < list_len) begin
                    if (list_words[i] == val) begin
                        for (j = i; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
                        list_len--;
                    end else i++;
                end
            end
            bale_pkg::FN_SORT: begin
                for (i = list_len; i > 0; i--)
                    for (j = 0; j + 1 < i; j++)
                        if ($signed(list_words[j]) > $signed(list_words[j+1])) begin
                            t = list_words[j];
                            list_words[j] = list_words[j+1];
                            list_words[j+1] = t;
                        end
            end
            bale_pkg::FN_BSEARCH: begin
                // probe the list as it stands, sorted or not
                lo = 0;
                hi = list_len;
                status = bale_pkg::ST_NOTFOUND;
                while (lo < hi) begin
                    mid = (lo + hi - 1) / 2;
                    if (list_words[mid] == val) begin
                        status = bale_pkg::ST_OK;
                        fnd = 1'b1;
                        idx = mid[3:0];
                        break;
                    end
                    if ($signed(list_words[mid]) < $signed(val)) lo = mid + 1;
                    else hi = mid;
                end
            end
            bale_pkg::FN_DUMP: begin
                if (list_len == 0) status = bale_pkg::ST_EMPTY;
                else begin
                    for (i = 0; i < list_len; i++) begin
                        r = '{bale_pkg::ST_OK, 4'd0, 1'b0, list_words[i], list_len[4:0],
                              (i + 1 == list_len)};
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
            bale_pkg::FN_CLEAR: list_len = 0;
            default: ;
        endcase
        r = '{status, idx, fnd, 32'd0, list_len[4:0], 1'b1};
        pending_results.push_back(r);
    endfunction

    // Offer one request; hold it until accepted.
    task automatic send_request(logic [3:0] fn, logic [4:0] pos, logic [31:0] val);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {7'd0, val, pos, fn};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_request(fn, pos, val);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4 * DEPTH) @(negedge aclk);
    endtask

    // Pick a value: mostly from a small pool so finds and removes hit.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 7) - 3;
        endcase
    endfunction

    // Score results at the rising edge.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[6:3], m_tdata[7], m_tdata[39:8],
                   m_tdata[44:40], m_tlast};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                recv_count++;
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.found_index !== want.found_index)
                    $display("%0t: found_index expected %0d actual %0d", $time,
                             want.found_index, got.found_index);
                if (got.found !== want.found)
                    $display("%0t: found expected %0d actual %0d", $time,
                             want.found, got.found);
                if (got.element !== want.element)
                    $display("%0t: element expected %h actual %h", $time,
                             want.element, got.element);
                if (got.item_count !== want.item_count)
                    $display("%0t: item_count expected %0d actual %0d", $time,
                             want.item_count, got.item_count);
                if (got.last !== want.last)
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, got.last);
                if (got !== want) error_count++;
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > TIMEOUT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result sink: random stall bursts, plus one long hold when asked.
    initial begin
        int gap;
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink && !hold_taken) begin
                m_tready <= 1'b0;
                repeat (long_hold) @(negedge aclk);
                hold_taken = 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        row_t        plan [$];
        row_t        rw;
        result_t     head;
        logic [3:0]  fn;
        int          n;
        int          k;
        table_errors = 0;
        sent_count = 0;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        long_hold = 0;
        list_len = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: empty-list rejects, extremes, full list, bad positions.
        plan.push_back('{bale_pkg::FN_POP_BACK, 5'd0, 32'd0, 1'b1, bale_pkg::ST_EMPTY, 5'd0});
        plan.push_back('{bale_pkg::FN_POP_FRONT, 5'd0, 32'd0, 1'b1, bale_pkg::ST_EMPTY, 5'd0});
        plan.push_back('{bale_pkg::FN_ERASE, 5'd0, 32'd0, 1'b1, bale_pkg::ST_EMPTY, 5'd0});
        plan.push_back('{bale_pkg::FN_DUMP, 5'd0, 32'd0, 1'b1, bale_pkg::ST_EMPTY, 5'd0});
        plan.push_back('{bale_pkg::FN_FIND, 5'd0, 32'd5, 1'b1, bale_pkg::ST_NOTFOUND, 5'd0});
        plan.push_back('{bale_pkg::FN_BSEARCH, 5'd0, 32'd5, 1'b1, bale_pkg::ST_NOTFOUND,
                         5'd0});
        plan.push_back('{bale_pkg::FN_INSERT, 5'd16, 32'd1, 1'b1, bale_pkg::ST_BADPOS, 5'd0});
        plan.push_back('{bale_pkg::FN_PUSH_BACK, 5'd0, 32'h7FFF_FFFF, 1'b1, bale_pkg::ST_OK,
                         5'd1});
        plan.push_back('{bale_pkg::FN_PUSH_FRONT, 5'd0, 32'h8000_0000, 1'b1, bale_pkg::ST_OK,
                         5'd2});
        plan.push_back('{bale_pkg::FN_INSERT, 5'd1, 32'hFFFF_FFFF, 1'b1, bale_pkg::ST_OK,
                         5'd3});
        plan.push_back('{bale_pkg::FN_ERASE, 5'd31, 32'd0, 1'b1, bale_pkg::ST_BADPOS, 5'd3});
        plan.push_back('{bale_pkg::FN_SORT, 5'd0, 32'd0, 1'b0, 3'd0, 5'd0});
        plan.push_back('{bale_pkg::FN_BSEARCH, 5'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, 5'd0});
        plan.push_back('{bale_pkg::FN_DUMP, 5'd0, 32'd0, 1'b0, 3'd0, 5'd0});
        for (k = 0; k < 13; k++)
            plan.push_back('{bale_pkg::FN_PUSH_BACK, 5'd0, 32'(k), 1'b0, 3'd0, 5'd0});
        plan.push_back('{bale_pkg::FN_PUSH_BACK, 5'd0, 32'd1, 1'b1, bale_pkg::ST_FULL, 5'd16});
        plan.push_back('{bale_pkg::FN_INSERT, 5'd3, 32'd1, 1'b1, bale_pkg::ST_FULL, 5'd16});
        plan.push_back('{bale_pkg::FN_REMOVE, 5'd0, 32'h7FFF_FFFF, 1'b0, 3'd0, 5'd0});
        plan.push_back('{bale_pkg::FN_REMOVE_ALL, 5'd0, 32'd9, 1'b0, 3'd0, 5'd0});
        plan.push_back('{4'd15, 5'd0, 32'd0, 1'b1, bale_pkg::ST_OK, 5'd14});
        plan.push_back('{bale_pkg::FN_CLEAR, 5'd0, 32'd0, 1'b1, bale_pkg::ST_OK, 5'd0});

        foreach (plan[i]) begin
            rw = plan[i];
            send_request(rw.fn, rw.pos, rw.val);
            if (rw.typed) begin
                head = pending_results[pending_results.size() - 1];
                if (head.status !== rw.status || head.item_count !== rw.count) begin
                    $display("%0t: table row %0d expected status %0d count %0d, model %0d %0d",
                             $time, i, rw.status, rw.count, head.status, head.item_count);
                    table_errors++;
                end
            end
        end
        drain_results();

        // Receiver holds off for a long stretch while requests keep coming.
        long_hold = 300;
        hold_sink = 1'b1;
        for (k = 0; k < 20; k++) send_request(bale_pkg::FN_DUMP, 5'd0, 32'd0);
        drain_results();

        // Random part: fill-biased traffic, with every field bit toggled.
        for (n = 0; n < 440; n++) begin
            if (n == 370) quiet_phase = 1'b1;
            if (n == 220) drain_results();
            k = $urandom_range(0, 99);
            if (k < 30 && list_len < DEPTH) fn = bale_pkg::FN_PUSH_BACK;
            else if (k < 95) fn = 4'($urandom_range(0, 12));
            else fn = 4'($urandom_range(13, 15));
            send_request(fn, 5'((k < 90) ? $urandom_range(0, list_len + 1)
                                         : $urandom_range(0, 31)), pick_value());
        end
        drain_results();

        $display("Covered %0d requests, %0d results scored, all functions plus full,",
                 sent_count, recv_count);
        $display("empty, bad-position, not-found and stalled-output cases.");
        if (error_count == 0 && table_errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
